### hdl/l2k_pkg.sv
// Shared constants, command codes and types of the Lanczos-2 kernel weight generator.
package l2k_pkg;

    localparam int RC_BITS     = 16;
    localparam int IDX_BITS    = 5;
    localparam int SUM_BITS    = 40;
    localparam int VAL_BITS    = 32;
    localparam int MIN_SAMPLES = 3;
    localparam int SINE_TERMS  = 5;

    localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
    localparam logic [31:0] PI_Q30   = 32'd3373259426;
    localparam logic [31:0] SC_MAX   = 32'h4400_0000;
    localparam logic [16:0] HALF_Q16 = 17'd32768;
    localparam logic [16:0] ONE_Q16  = 17'd65536;

    localparam logic OP_TAP  = 1'b0;
    localparam logic OP_NORM = 1'b1;

    typedef struct packed {
        logic start;
        logic op;
    } t_eng_cmd;

    // Divisors of the nested Taylor evaluation, innermost term first.
    function automatic logic [7:0] taylor_div(input logic [2:0] k);
        logic [7:0] d;
        case (k)
            3'd0:    d = 8'd110;
            3'd1:    d = 8'd72;
            3'd2:    d = 8'd42;
            3'd3:    d = 8'd20;
            default: d = 8'd6;
        endcase
        return d;
    endfunction

endpackage

### hdl/l2k_req_if.sv
// Request channel: one scale ratio word.
interface l2k_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] scale_ratio;

    modport source (output valid, output scale_ratio, input ready);
    modport sink   (input valid, input scale_ratio, output ready);
endinterface

### hdl/l2k_tap_if.sv
// Result channel: one kernel tap word.
interface l2k_tap_if #(
    parameter int WEIGHT_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic [3:0]                    tap_index;
    logic signed [WEIGHT_BITS-1:0] tap_weight;
    logic [3:0]                    tap_count;
    logic                          last_tap;

    modport source (output valid, output tap_index, output tap_weight, output tap_count,
                    output last_tap, input ready);
    modport sink   (input valid, input tap_index, input tap_weight, input tap_count,
                    input last_tap, output ready);
endinterface

### hdl/l2k_mul.sv
// Bit-serial 32x32 unsigned multiplier, one multiplier bit per cycle.
module l2k_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);
    logic [31:0] r_a, r_hi, r_lo;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] w_sum;

    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : 33'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            // add into the high half, shift the pair right
            r_hi <= w_sum[32:1];
            r_lo <= {w_sum[0], r_lo[31:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};
endmodule

### hdl/l2k_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module l2k_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [6:0]  i_steps,
    input  logic [39:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    logic [63:0] r_num, r_quo;
    logic [39:0] r_rem, r_den;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [40:0] w_rs;
    logic        w_ge;

    assign w_rs = {r_rem, r_num[63]};
    assign w_ge = (w_rs >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[62:0], 1'b0};
            r_rem <= w_ge ? 40'(w_rs - {1'b0, r_den}) : w_rs[39:0];
            r_quo <= {r_quo[62:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

### hdl/l2k_eng.sv
// Tap value and normalization sequencer around the serial multiplier and divider.
module l2k_eng #(
    parameter int WEIGHT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  l2k_pkg::t_eng_cmd                 i_cmd,
    input  logic [l2k_pkg::IDX_BITS-1:0]      i_idx,
    input  logic [l2k_pkg::RC_BITS-1:0]       i_rc,
    input  logic signed [l2k_pkg::VAL_BITS-1:0] i_val,
    input  logic signed [l2k_pkg::SUM_BITS-1:0] i_sum,
    output logic                              o_done,
    output logic signed [l2k_pkg::VAL_BITS-1:0] o_val,
    output logic signed [WEIGHT_BITS-1:0]     o_weight
);
    localparam logic [4:0] E_IDLE = 5'd0,  E_WAIT = 5'd1,  E_TCHK = 5'd2,  E_SPI = 5'd3,
                           E_STH  = 5'd4,  E_ST2  = 5'd5,  E_SLP  = 5'd6,  E_SDV = 5'd7,
                           E_SSB  = 5'd8,  E_SFN  = 5'd9,  E_SRS  = 5'd10, E_PPT = 5'd11,
                           E_PSC  = 5'd12, E_CST  = 5'd13, E_MSQ  = 5'd14, E_MFN = 5'd15,
                           E_NFIN = 5'd16;
    localparam logic [63:0] HALF_W = 64'd1 << (WEIGHT_BITS - 1);

    logic [4:0]  r_state, n_state, r_ret, n_ret;
    logic        r_call, n_call, r_neg, n_neg, r_done, n_done;
    logic [16:0] r_t, n_t, r_u, n_u;
    logic [30:0] r_th, n_th, r_s, n_s, r_sc, n_sc, r_c, n_c;
    logic [31:0] r_t2, n_t2, r_p, n_p;
    logic [2:0]  r_k, n_k;
    logic signed [l2k_pkg::VAL_BITS-1:0] r_val, n_val;
    logic signed [WEIGHT_BITS-1:0]       r_wt, n_wt;

    logic        mul_start, mul_done, div_start, div_done;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p, div_num, div_quo;
    logic [6:0]  div_steps;
    logic [39:0] div_den;

    logic [31:0] w_mag, w_pt;
    logic [30:0] w_m;

    l2k_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start), .i_a(mul_a), .i_b(mul_b),
        .o_done(mul_done), .o_prod(mul_p)
    );

    l2k_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_num(div_num),
        .i_steps(div_steps), .i_den(div_den), .o_done(div_done), .o_quo(div_quo)
    );

    assign w_mag = i_val[l2k_pkg::VAL_BITS-1] ? 32'(-i_val) : 32'(i_val);
    assign w_pt  = mul_p[47:16];
    assign w_m   = mul_p[60:30];

    always_comb begin
        n_state = r_state; n_ret = r_ret; n_call = r_call; n_neg = r_neg;
        n_t = r_t; n_u = r_u; n_th = r_th; n_s = r_s; n_sc = r_sc; n_c = r_c;
        n_t2 = r_t2; n_p = r_p; n_k = r_k; n_val = r_val; n_wt = r_wt; n_done = 1'b0;
        mul_start = 1'b0; mul_a = '0; mul_b = '0;
        div_start = 1'b0; div_num = '0; div_steps = '0; div_den = '0;
        case (r_state)
            E_IDLE: begin
                if (i_cmd.start) begin
                    if (i_cmd.op == l2k_pkg::OP_NORM) begin
                        n_neg     = i_val[l2k_pkg::VAL_BITS-1];
                        div_start = 1'b1;
                        div_num   = (64'(w_mag) << (WEIGHT_BITS - 2))
                                    + 64'($unsigned(i_sum) >> 1);
                        div_steps = 7'd64;
                        div_den   = $unsigned(i_sum);
                        n_ret     = E_NFIN;
                        n_state   = E_WAIT;
                    end else if (i_idx == '0) begin
                        n_val  = $signed(l2k_pkg::ONE_Q30);
                        n_done = 1'b1;
                    end else if (i_rc == '0) begin
                        n_val  = '0;
                        n_done = 1'b1;
                    end else begin
                        div_start = 1'b1;
                        div_num   = {32'(i_idx) << 27, 32'd0};
                        div_steps = 7'd32;
                        div_den   = 40'(i_rc);
                        n_ret     = E_TCHK;
                        n_state   = E_WAIT;
                    end
                end
            end
            E_WAIT: begin
                if (mul_done || div_done) begin
                    n_state = r_ret;
                end
            end
            E_TCHK: begin
                if (div_quo >= 64'(l2k_pkg::ONE_Q16)) begin
                    n_val   = '0;
                    n_done  = 1'b1;
                    n_state = E_IDLE;
                end else begin
                    n_t     = div_quo[16:0];
                    n_u     = (div_quo[16:0] <= l2k_pkg::HALF_Q16) ? div_quo[16:0]
                              : 17'(l2k_pkg::ONE_Q16 - div_quo[16:0]);
                    n_call  = 1'b0;
                    n_state = E_SPI;
                end
            end
            E_SPI: begin
                mul_start = 1'b1;
                mul_a     = l2k_pkg::PI_Q30;
                mul_b     = 32'((r_u > l2k_pkg::HALF_Q16) ? l2k_pkg::HALF_Q16 : r_u);
                n_ret     = E_STH;
                n_state   = E_WAIT;
            end
            E_STH: begin
                n_th      = mul_p[46:16];
                mul_start = 1'b1;
                mul_a     = 32'(mul_p[46:16]);
                mul_b     = 32'(mul_p[46:16]);
                n_ret     = E_ST2;
                n_state   = E_WAIT;
            end
            E_ST2: begin
                n_t2    = mul_p[61:30];
                n_p     = l2k_pkg::ONE_Q30;
                n_k     = '0;
                n_state = E_SLP;
            end
            E_SLP: begin
                mul_start = 1'b1;
                mul_a     = r_t2;
                mul_b     = r_p;
                n_ret     = E_SDV;
                n_state   = E_WAIT;
            end
            E_SDV: begin
                div_start = 1'b1;
                div_num   = {mul_p[61:30], 32'd0};
                div_steps = 7'd32;
                div_den   = 40'(l2k_pkg::taylor_div(r_k));
                n_ret     = E_SSB;
                n_state   = E_WAIT;
            end
            E_SSB: begin
                n_p = l2k_pkg::ONE_Q30 - div_quo[31:0];
                if (r_k == 3'(l2k_pkg::SINE_TERMS - 1)) begin
                    n_state = E_SFN;
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = E_SLP;
                end
            end
            E_SFN: begin
                mul_start = 1'b1;
                mul_a     = 32'(r_th);
                mul_b     = r_p;
                n_ret     = E_SRS;
                n_state   = E_WAIT;
            end
            E_SRS: begin
                mul_start = 1'b1;
                n_state   = E_WAIT;
                if (!r_call) begin
                    n_s   = w_m;
                    mul_a = l2k_pkg::PI_Q30;
                    mul_b = 32'(r_t);
                    n_ret = E_PPT;
                end else begin
                    n_c   = w_m;
                    mul_a = 32'(r_sc);
                    mul_b = 32'(r_sc);
                    n_ret = E_MSQ;
                end
            end
            E_PPT: begin
                if (w_pt == '0) begin
                    n_sc    = 31'(l2k_pkg::ONE_Q30);
                    n_state = E_CST;
                end else begin
                    div_start = 1'b1;
                    div_num   = 64'(r_s) << 30;
                    div_steps = 7'd64;
                    div_den   = 40'(w_pt);
                    n_ret     = E_PSC;
                    n_state   = E_WAIT;
                end
            end
            E_PSC: begin
                n_sc    = (div_quo > 64'(l2k_pkg::SC_MAX)) ? 31'(l2k_pkg::SC_MAX)
                          : div_quo[30:0];
                n_state = E_CST;
            end
            E_CST: begin
                n_neg   = (r_t > l2k_pkg::HALF_Q16);
                n_u     = (r_t > l2k_pkg::HALF_Q16) ? 17'(r_t - l2k_pkg::HALF_Q16)
                          : 17'(l2k_pkg::HALF_Q16 - r_t);
                n_call  = 1'b1;
                n_state = E_SPI;
            end
            E_MSQ: begin
                mul_start = 1'b1;
                mul_a     = 32'(w_m);
                mul_b     = 32'(r_c);
                n_ret     = E_MFN;
                n_state   = E_WAIT;
            end
            E_MFN: begin
                n_val   = r_neg ? -$signed(32'(w_m)) : $signed(32'(w_m));
                n_done  = 1'b1;
                n_state = E_IDLE;
            end
            E_NFIN: begin
                if (r_neg) begin
                    n_wt = (div_quo >= HALF_W) ? $signed(WEIGHT_BITS'(HALF_W))
                           : -$signed(WEIGHT_BITS'(div_quo));
                end else begin
                    n_wt = (div_quo >= HALF_W) ? $signed(WEIGHT_BITS'(HALF_W - 64'd1))
                           : $signed(WEIGHT_BITS'(div_quo));
                end
                n_done  = 1'b1;
                n_state = E_IDLE;
            end
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_ret   <= E_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_call <= n_call; r_neg <= n_neg; r_t <= n_t; r_u <= n_u; r_th <= n_th;
        r_s <= n_s; r_sc <= n_sc; r_c <= n_c; r_t2 <= n_t2; r_p <= n_p; r_k <= n_k;
        r_val <= n_val; r_wt <= n_wt;
    end

    assign o_done   = r_done;
    assign o_val    = r_val;
    assign o_weight = r_wt;
endmodule

### hdl/lanczos2_kernel_weight_generator_unit.sv
// Top level: tap count, tap value store, symmetric sum and normalized tap output.
//
// Usage:
//   i_req carries one scale ratio word (source over target size, unsigned Q4.12).
//   o_tap returns the one-sided kernel, center tap first: tap_index, the weight in
//   signed Q2.(WEIGHT_BITS-2), the tap count (same in every word) and last_tap on
//   the final tap. Both channels move a word when valid and ready are high.
// Sequencing:
//   One request at a time; i_req.ready is high only between requests. Each side
//   tap value goes through a bit-serial multiplier and a bit-serial divider that
//   deliver one bit per cycle; a value takes 19 products and 12 quotients. The
//   center tap is set directly, and a side tap beyond the kernel support ends
//   after its first quotient. The normalizing pass runs one quotient per tap;
//   the first word leaves after the last tap value is known.
// Reset: synchronous, active low; clears the sequencers and the output valid flag.
// Stall: a held output word stays stable; the next normalized weight is computed
//   meanwhile and waits until the word is taken.
module lanczos2_kernel_weight_generator_unit #(
    parameter int MAX_SAMPLES = 29,
    parameter int WEIGHT_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    l2k_req_if.sink    i_req,
    l2k_tap_if.source  o_tap
);
    localparam int MAX_TAPS = MAX_SAMPLES / 2 + 1;
    localparam int CW       = $clog2(MAX_TAPS + 1);
    localparam int IW       = $clog2(MAX_TAPS);

    localparam logic [2:0] T_IDLE = 3'd0, T_CALC = 3'd1, T_CWT = 3'd2, T_FIX = 3'd3,
                           T_NORM = 3'd4, T_NWT  = 3'd5, T_OUT = 3'd6;

    logic [2:0]  r_state;
    logic [15:0] r_rc;
    logic [CW-1:0] r_cnt, r_i;
    logic signed [l2k_pkg::VAL_BITS-1:0] r_vals [MAX_TAPS];
    logic signed [l2k_pkg::SUM_BITS-1:0] r_sum;
    logic        r_ovalid, r_olast;
    logic [3:0]  r_oidx, r_ocnt;
    logic signed [WEIGHT_BITS-1:0] r_owt;

    logic [5:0]  w_ceil2;
    logic [6:0]  w_samples;
    logic [CW-1:0] w_count;
    logic        w_last, w_out_free;
    logic signed [l2k_pkg::SUM_BITS-1:0] w_v40;

    l2k_pkg::t_eng_cmd eng_cmd;
    logic        eng_done;
    logic signed [l2k_pkg::VAL_BITS-1:0] eng_val;
    logic signed [WEIGHT_BITS-1:0] eng_wt;

    always_comb begin
        w_ceil2 = 6'((17'(i_req.scale_ratio) + 17'd2047) >> 11);
        if (w_ceil2 < 6'd2) begin
            w_samples = 7'(l2k_pkg::MIN_SAMPLES);
        end else begin
            w_samples = 7'({1'b0, w_ceil2} * 7'd2 - 7'd1);
        end
        if (w_samples > 7'(MAX_SAMPLES)) begin
            w_samples = 7'(MAX_SAMPLES);
        end
        w_count = CW'((w_samples >> 1) + 7'd1);
    end

    assign w_last     = (CW'(r_i + 1'b1) == r_cnt);
    assign w_out_free = !r_ovalid || o_tap.ready;
    assign w_v40      = l2k_pkg::SUM_BITS'(eng_val);

    assign eng_cmd.start = (r_state == T_CALC) || (r_state == T_NORM);
    assign eng_cmd.op    = (r_state == T_NORM) ? l2k_pkg::OP_NORM : l2k_pkg::OP_TAP;

    l2k_eng #(.WEIGHT_BITS(WEIGHT_BITS)) u_eng (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(eng_cmd),
        .i_idx(l2k_pkg::IDX_BITS'(r_i)), .i_rc(r_rc), .i_val(r_vals[r_i[IW-1:0]]),
        .i_sum(r_sum), .o_done(eng_done), .o_val(eng_val), .o_weight(eng_wt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_IDLE;
            r_ovalid <= 1'b0;
            r_i      <= '0;
            r_cnt    <= '0;
        end else begin
            if (r_state == T_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_tap.valid && o_tap.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                T_IDLE: begin
                    if (i_req.valid) begin
                        r_cnt   <= w_count;
                        r_i     <= '0;
                        r_state <= T_CALC;
                    end
                end
                T_CALC: r_state <= T_CWT;
                T_CWT: begin
                    if (eng_done) begin
                        if (w_last) begin
                            r_i     <= '0;
                            r_state <= T_FIX;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= T_CALC;
                        end
                    end
                end
                T_FIX:  r_state <= T_NORM;
                T_NORM: r_state <= T_NWT;
                T_NWT: begin
                    if (eng_done) begin
                        r_state <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (w_out_free) begin
                        if (w_last) begin
                            r_state <= T_IDLE;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= T_NORM;
                        end
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    // payload side
    always_ff @(posedge i_clk) begin
        if (r_state == T_IDLE && i_req.valid) begin
            r_rc  <= i_req.scale_ratio;
            r_sum <= '0;
        end
        if (r_state == T_CWT && eng_done) begin
            r_vals[r_i[IW-1:0]] <= eng_val;
            r_sum <= r_sum + ((r_i == '0) ? w_v40 : (w_v40 <<< 1));
        end
        if (r_state == T_FIX && r_sum <= 0) begin
            r_sum <= l2k_pkg::SUM_BITS'(l2k_pkg::ONE_Q30);
        end
        if (r_state == T_OUT && w_out_free) begin
            r_oidx  <= 4'(r_i);
            r_ocnt  <= 4'(r_cnt);
            r_olast <= w_last;
            r_owt   <= eng_wt;
        end
    end

    assign i_req.ready      = (r_state == T_IDLE);
    assign o_tap.valid      = r_ovalid;
    assign o_tap.tap_index  = r_oidx;
    assign o_tap.tap_weight = r_owt;
    assign o_tap.tap_count  = r_ocnt;
    assign o_tap.last_tap   = r_olast;

    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while another is in flight");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tap.valid && o_tap.last_tap) |-> (4'(o_tap.tap_index + 4'd1) == o_tap.tap_count))
        else $error("last tap flag not on the final index");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != T_IDLE) |-> (r_cnt >= CW'(2) && r_cnt <= CW'(MAX_TAPS)))
        else $error("tap count out of range");

    a_sum_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_NORM) |-> (r_sum > 0))
        else $error("normalizing with a non-positive sum");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != T_IDLE) |-> (r_i < r_cnt))
        else $error("tap index beyond count");
endmodule
